// File: hw/rtl/jdbs_pkg.sv
// Shared types and constants for the joystick dead-zone and button select block.
`default_nettype none
package jdbs_pkg;

	// Field widths
	localparam int SAMPLE_W = 10;
	localparam int TIME_W   = 32;
	localparam int DELAY_W  = 16;
	localparam int DELTA_W  = 5;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	// Axis shaping
	localparam logic [SAMPLE_W-1:0] DEAD_ZONE   = SAMPLE_W'(4);
	localparam int                  SCALE_SHIFT = 7;
	localparam logic [SAMPLE_W-1:0] POS_LIMIT   = SAMPLE_W'(15);
	localparam logic [SAMPLE_W-1:0] NEG_LIMIT   = SAMPLE_W'(16);

	// Register reset values
	localparam logic [SAMPLE_W-1:0] CENTER_RST = SAMPLE_W'(512);
	localparam logic [DELAY_W-1:0]  DELAY_RST  = DELAY_W'(200);

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_CENTER_H = 2'd0,
		REG_CENTER_V = 2'd1,
		REG_DELAY    = 2'd2
	} reg_idx_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [SAMPLE_W-1:0] center_h;
		logic [SAMPLE_W-1:0] center_v;
		logic [DELAY_W-1:0]  sample_delay;
	} cfg_t;

	// Button sampler control from the pipeline
	typedef struct packed {
		logic               take;
		logic               pressed;
		logic [TIME_W-1:0]  now_ms;
	} btn_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/jdbs_if.sv
// Valid/ready channel interfaces for sample sets and results.
`default_nettype none
interface jdbs_in_if;
	logic        valid;
	logic        ready;
	logic [9:0]  horizontal_sample;
	logic [9:0]  vertical_sample;
	logic        button_pressed;
	logic [31:0] now_ms;

	modport source (output valid, horizontal_sample, vertical_sample, button_pressed, now_ms,
		input ready);
	modport sink (input valid, horizontal_sample, vertical_sample, button_pressed, now_ms,
		output ready);
endinterface

interface jdbs_out_if;
	logic              valid;
	logic              ready;
	logic signed [4:0] delta_horizontal;
	logic signed [4:0] delta_vertical;
	logic              select_event;

	modport source (output valid, delta_horizontal, delta_vertical, select_event,
		input ready);
	modport sink (input valid, delta_horizontal, delta_vertical, select_event,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/jdbs_cfg_regs.sv
// APB-style configuration registers: axis centers and button sample delay.
`default_nettype none
module jdbs_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [jdbs_pkg::PADDR_W-1:0] paddr,
	input  wire logic [jdbs_pkg::PDATA_W-1:0] pwdata,
	output logic      [jdbs_pkg::PDATA_W-1:0] prdata,
	output jdbs_pkg::cfg_t                    cfg
);
	import jdbs_pkg::*;

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_h     <= CENTER_RST;
			cfg_q.center_v     <= CENTER_RST;
			cfg_q.sample_delay <= DELAY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_CENTER_H: cfg_q.center_h     <= pwdata[SAMPLE_W-1:0];
				REG_CENTER_V: cfg_q.center_v     <= pwdata[SAMPLE_W-1:0];
				REG_DELAY:    cfg_q.sample_delay <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_CENTER_H: prdata = PDATA_W'(cfg_q.center_h);
			REG_CENTER_V: prdata = PDATA_W'(cfg_q.center_v);
			REG_DELAY:    prdata = PDATA_W'(cfg_q.sample_delay);
			default:      prdata = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_delay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && idx == REG_DELAY) |=> $stable(cfg_q.sample_delay))
		else $error("sample delay changed without a write");
	a_center_h_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && idx == REG_CENTER_H) |=> $stable(cfg_q.center_h))
		else $error("horizontal center changed without a write");
	a_delay_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && idx == REG_DELAY) |=> cfg_q.sample_delay == $past(pwdata[DELAY_W-1:0]))
		else $error("sample delay write lost");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/jdbs_axis.sv
// One axis: negated offset from center, dead zone, scale with truncation, saturation.
`default_nettype none
module jdbs_axis (
	input  wire logic        [jdbs_pkg::SAMPLE_W-1:0] sample,
	input  wire logic        [jdbs_pkg::SAMPLE_W-1:0] center,
	output logic signed      [jdbs_pkg::DELTA_W-1:0]  delta
);
	import jdbs_pkg::*;

	logic signed [SAMPLE_W:0] off;
	logic [SAMPLE_W-1:0]      mag;
	logic [SAMPLE_W-1:0]      mag_dz;
	logic [SAMPLE_W-1:0]      q;

	always_comb begin
		// center - sample, one extra bit for sign
		off    = $signed({1'b0, center}) - $signed({1'b0, sample});
		mag    = off[SAMPLE_W] ? SAMPLE_W'(-off) : off[SAMPLE_W-1:0];
		mag_dz = (mag <= DEAD_ZONE) ? '0 : mag;
		q      = mag_dz >> SCALE_SHIFT;
		// restore sign and clamp to the output range
		if (off[SAMPLE_W]) begin
			delta = (q >= NEG_LIMIT) ? DELTA_W'(-NEG_LIMIT) : DELTA_W'(-q);
		end else begin
			delta = (q >= POS_LIMIT) ? DELTA_W'(POS_LIMIT) : DELTA_W'(q);
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/jdbs_button.sv
// Rate-limited button sampler and release detector.
`default_nettype none
module jdbs_button (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire jdbs_pkg::btn_req_t            req,
	input  wire logic [jdbs_pkg::DELAY_W-1:0]  sample_delay,
	output logic                               select
);
	import jdbs_pkg::*;

	logic [TIME_W-1:0] last_q;
	logic              held_q;
	logic [TIME_W-1:0] last_eff;
	logic [TIME_W-1:0] deadline;
	logic              do_sample;

	always_comb begin
		// time moving backward reloads the last sample time
		last_eff  = (req.now_ms < last_q) ? req.now_ms : last_q;
		deadline  = last_eff + TIME_W'(sample_delay);
		do_sample = (last_eff == '0) || (deadline < req.now_ms);
		select    = do_sample && held_q && !req.pressed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			held_q <= 1'b0;
		end else if (req.take) begin
			if (do_sample) begin
				last_q <= req.now_ms;
				held_q <= req.pressed;
			end else begin
				last_q <= last_eff;
			end
		end
	end

`ifndef ASSERT_OFF
	a_select_release: assert property (@(posedge clk) disable iff (!arst_n)
		(req.take && select) |=> !held_q)
		else $error("select without release");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!req.take |=> $stable(held_q) && $stable(last_q))
		else $error("button state moved without a transaction");
	a_sample_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.take && do_sample) |=> last_q == $past(req.now_ms))
		else $error("sample time not recorded");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/joystick_deadzone_button_select_core.sv
// Top level: joystick dead-zone filter with rate-limited button select.
//
//  channel   dir  handshake          payload
//  samples   in   valid/ready        horizontal_sample, vertical_sample, button_pressed, now_ms
//  results   out  valid/ready        delta_horizontal, delta_vertical, select_event
//  apb       in   psel/penable       paddr[3:0], pwdata, prdata; pready tied high
//
// Two register stages: input register (_s1), result register (_s2).
// One transaction per cycle sustained while results are taken; axis math and button compare sit between the stages.
// The 32-bit deadline add and compare in the button sampler sets the critical path.
// A stalled result holds both stages; the input side takes a new transaction while s1 drains.
// Reset clears valids, centers to 512, delay to 200, button state to released.
`default_nettype none
module joystick_deadzone_button_select_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [jdbs_pkg::PADDR_W-1:0] paddr,
	input  wire logic [jdbs_pkg::PDATA_W-1:0] pwdata,
	output logic      [jdbs_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	jdbs_in_if.sink                           samples,
	jdbs_out_if.source                        results
);
	import jdbs_pkg::*;

	cfg_t                       cfg;
	btn_req_t                   btn_req;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       advance;
	logic                       in_take;
	logic [SAMPLE_W-1:0]        h_s1;
	logic [SAMPLE_W-1:0]        v_s1;
	logic                       pressed_s1;
	logic [TIME_W-1:0]          now_s1;
	logic signed [DELTA_W-1:0]  dh;
	logic signed [DELTA_W-1:0]  dv;
	logic                       sel;
	logic signed [DELTA_W-1:0]  dh_s2;
	logic signed [DELTA_W-1:0]  dv_s2;
	logic                       sel_s2;

	assign pready = 1'b1;

	jdbs_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Pipeline flow control
	assign advance       = !valid_s2 || results.ready;
	assign samples.ready = !valid_s1 || advance;
	assign in_take       = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_take) begin
			h_s1       <= samples.horizontal_sample;
			v_s1       <= samples.vertical_sample;
			pressed_s1 <= samples.button_pressed;
			now_s1     <= samples.now_ms;
		end
	end

	jdbs_axis u_axis_h (.sample(h_s1), .center(cfg.center_h), .delta(dh));
	jdbs_axis u_axis_v (.sample(v_s1), .center(cfg.center_v), .delta(dv));

	assign btn_req.take    = valid_s1 && advance;
	assign btn_req.pressed = pressed_s1;
	assign btn_req.now_ms  = now_s1;

	jdbs_button u_button (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (btn_req),
		.sample_delay (cfg.sample_delay),
		.select       (sel)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (btn_req.take) begin
			dh_s2  <= dh;
			dv_s2  <= dv;
			sel_s2 <= sel;
		end
	end

	assign results.valid            = valid_s2;
	assign results.delta_horizontal = dh_s2;
	assign results.delta_vertical   = dv_s2;
	assign results.select_event     = sel_s2;

`ifndef ASSERT_OFF
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage dropped a stalled transaction");
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted transaction not captured");
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		btn_req.take |=> valid_s2)
		else $error("processed transaction not in result register");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && results.ready && !valid_s1) |=> !valid_s2)
		else $error("result repeated");
`endif
endmodule
`default_nettype wire

// File: tb/joystick_deadzone_button_select_core_tb.sv
// Self-checking testbench for the joystick dead-zone filter and button select core.
module joystick_deadzone_button_select_core_tb;
	import jdbs_pkg::*;

	localparam int         WATCHDOG_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES    = 4;
	localparam int         RANDOM_PHASES   = 7;
	localparam int         ITEMS_PER_PHASE = 200;
	localparam int         MAX_PRINTED     = 100;
	localparam logic [1:0] REG_UNUSED      = 2'd3;

	typedef struct packed {
		logic signed [DELTA_W-1:0] dh;
		logic signed [DELTA_W-1:0] dv;
		logic                      select;
	} stick_move_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	jdbs_in_if  samples_ch ();
	jdbs_out_if results_ch ();

	joystick_deadzone_button_select_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples_ch),
		.results (results_ch)
	);

	// Shadow copy of the registers and button sampler state
	logic [SAMPLE_W-1:0] ctr_h       = CENTER_RST;
	logic [SAMPLE_W-1:0] ctr_v       = CENTER_RST;
	logic [DELAY_W-1:0]  btn_delay   = DELAY_RST;
	logic [TIME_W-1:0]   last_btn_ms = '0;
	logic                btn_held    = 1'b0;

	stick_move_t pending_moves[$];

	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	int err_count       = 0;
	int samples_sent    = 0;
	int moves_checked   = 0;
	int selects_seen    = 0;
	int configs_written = 0;
	int quiet_cycles    = 0;

	always #10 clk = ~clk;

	// Axis shaping: negated offset, dead zone, divide with truncation, saturate
	function automatic logic signed [DELTA_W-1:0] axis_delta(
		input logic [SAMPLE_W-1:0] reading,
		input logic [SAMPLE_W-1:0] center
	);
		int offset;
		int mag;
		int q;
		offset = int'(center) - int'(reading);
		mag = (offset < 0) ? -offset : offset;
		if (mag <= int'(DEAD_ZONE))
			mag = 0;
		q = mag >> SCALE_SHIFT;
		if (offset < 0)
			q = -q;
		if (q > int'(POS_LIMIT))
			q = int'(POS_LIMIT);
		if (q < -int'(NEG_LIMIT))
			q = -int'(NEG_LIMIT);
		return q[DELTA_W-1:0];
	endfunction

	// Expected move for one accepted sample set; advances the sampler state
	function automatic stick_move_t predict_move(
		input logic [SAMPLE_W-1:0] h,
		input logic [SAMPLE_W-1:0] v,
		input logic                pressed,
		input logic [TIME_W-1:0]   now
	);
		stick_move_t       m;
		logic [TIME_W-1:0] deadline;
		m.dh = axis_delta(h, ctr_h);
		m.dv = axis_delta(v, ctr_v);
		m.select = 1'b0;
		// time that runs backward restarts the interval
		if (now < last_btn_ms)
			last_btn_ms = now;
		deadline = last_btn_ms + TIME_W'(btn_delay);
		if (last_btn_ms == '0 || deadline < now) begin
			last_btn_ms = now;
			if (btn_held != pressed) begin
				m.select = btn_held;
				btn_held = pressed;
			end
		end
		return m;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("MISMATCH result %0d %s: got %0d, expected %0d",
				moves_checked, field, got, want);
	endtask

	// Source side: optional gap, then hold valid until the transaction is taken
	task automatic send_sample(
		input logic [SAMPLE_W-1:0] h,
		input logic [SAMPLE_W-1:0] v,
		input logic                pressed,
		input logic [TIME_W-1:0]   now
	);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid             <= 1'b1;
		samples_ch.horizontal_sample <= h;
		samples_ch.vertical_sample   <= v;
		samples_ch.button_pressed    <= pressed;
		samples_ch.now_ms            <= now;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		pending_moves.push_back(predict_move(h, v, pressed, now));
		samples_sent++;
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain_moves();
		samples_ch.valid <= 1'b0;
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup then access; lines stay up until apb_release
	task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_CENTER_H)
			ctr_h = data[SAMPLE_W-1:0];
		else if (idx == REG_CENTER_V)
			ctr_v = data[SAMPLE_W-1:0];
		else if (idx == REG_DELAY)
			btn_delay = data[DELAY_W-1:0];
		configs_written++;
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Program all three registers; upper data bits carry junk
	task automatic apply_config(
		input logic [SAMPLE_W-1:0] h,
		input logic [SAMPLE_W-1:0] v,
		input logic [DELAY_W-1:0]  d
	);
		logic [PDATA_W-1:0] junk;
		drain_moves();
		junk = $urandom();
		apb_write(REG_CENTER_H, {junk[PDATA_W-1:SAMPLE_W], h});
		apb_write(REG_CENTER_V, {junk[PDATA_W-1:SAMPLE_W], v});
		apb_write(REG_DELAY, {junk[PDATA_W-1:DELAY_W], d});
		apb_release();
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_center();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return r[SAMPLE_W-1:0];
		endcase
	endfunction

	// Half full-range readings, half clustered around the center
	function automatic logic [SAMPLE_W-1:0] pick_reading(input logic [SAMPLE_W-1:0] center);
		logic [31:0] r;
		int          val;
		r = $urandom();
		if (r[31])
			return r[SAMPLE_W-1:0];
		val = int'(center) + int'($urandom_range(0, 20)) - 10;
		if (val < 0)
			val = 0;
		if (val > 1023)
			val = 1023;
		return val[SAMPLE_W-1:0];
	endfunction

	// Dead zone edges, one-step offsets and full-scale readings at default centers
	task automatic test_axis_deadzone();
		send_sample(10'd0, 10'd1023, 1'b1, 32'd0);
		send_sample(10'd1023, 10'd0, 1'b0, 32'd0);
		send_sample(10'd508, 10'd516, 1'b1, 32'd100);
		send_sample(10'd507, 10'd517, 1'b0, 32'd300);
		send_sample(10'd384, 10'd640, 1'b0, 32'd301);
	endtask

	// Sample interval edge, time running backward, return to zero, deadline wrap
	task automatic test_button_sampling();
		send_sample(10'd385, 10'd639, 1'b1, 32'd50);
		send_sample(10'd500, 10'd524, 1'b1, 32'd250);
		send_sample(10'd520, 10'd504, 1'b1, 32'd251);
		send_sample(10'd512, 10'd512, 1'b0, 32'd0);
		send_sample(10'd256, 10'd768, 1'b1, 32'hFFFF_FFF0);
		send_sample(10'd768, 10'd256, 1'b0, 32'hFFFF_FFFF);
		send_sample(10'd1, 10'd1022, 1'b1, 32'hFFFF_FFFF);
	endtask

	// Register extremes and a write to an unmapped address
	task automatic test_register_extremes();
		apply_config(10'd0, 10'd1023, 16'd0);
		send_sample(10'd1023, 10'd0, 1'b0, 32'd5);
		send_sample(10'd1023, 10'd0, 1'b0, 32'd6);
		send_sample(10'd0, 10'd1023, 1'b1, 32'd6);
		apply_config(10'd1023, 10'd0, 16'hFFFF);
		send_sample(10'd0, 10'd1023, 1'b1, 32'd7);
		send_sample(10'd0, 10'd1023, 1'b1, 32'd65542);
		send_sample(10'd0, 10'd1023, 1'b0, 32'd131078);
		drain_moves();
		apb_write(REG_UNUSED, $urandom());
		apb_release();
		send_sample(10'd700, 10'd300, 1'b1, 32'd131079);
	endtask

	// Random phases, each with its own settings and idling mix
	task automatic test_random_traffic();
		logic [TIME_W-1:0]  now;
		logic               pressed;
		logic [DELAY_W-1:0] d;
		int                 pick;
		now = 32'd1000;
		pressed = 1'b0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			src_idle = (phase % 4 == 0) || (phase % 4 == 1);
			snk_idle = (phase % 4 == 0) || (phase % 4 == 2);
			case ($urandom_range(0, 5))
				0: d = '0;
				1: d = '1;
				2: d = DELAY_RST;
				3: d = 16'd1;
				4: d = DELAY_W'($urandom_range(0, 2000));
				default: d = DELAY_W'($urandom_range(0, 65535));
			endcase
			apply_config(pick_center(), pick_center(), d);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// mostly forward time around the sample interval, some jumps
				pick = $urandom_range(0, 99);
				if (pick < 3)
					now = now - TIME_W'($urandom_range(1, 5000));
				else if (pick < 5)
					now = $urandom();
				else if (pick < 7)
					now = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 2 * int'(btn_delay) + 2));
				else if (pick < 9)
					now = TIME_W'($urandom_range(0, 3));
				else
					now = now + TIME_W'($urandom_range(0, 2 * int'(btn_delay) + 2));
				// held presses with releases, plus some chatter
				pick = $urandom_range(0, 99);
				if (pick < 10)
					pressed = 1'($urandom_range(0, 1));
				else if (pick < 35)
					pressed = ~pressed;
				send_sample(pick_reading(ctr_h), pick_reading(ctr_v), pressed, now);
			end
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	// Sink side: random stalls, compare each result with the oldest expectation
	initial begin : result_sink
		int          stall;
		stick_move_t want;
		results_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = snk_idle ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			@(posedge clk);
			while (!results_ch.valid)
				@(posedge clk);
			moves_checked++;
			if (pending_moves.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = pending_moves.pop_front();
				if (want.select)
					selects_seen++;
				if (results_ch.delta_horizontal !== want.dh)
					report_mismatch("delta_horizontal", int'(results_ch.delta_horizontal),
						int'(want.dh));
				if (results_ch.delta_vertical !== want.dv)
					report_mismatch("delta_vertical", int'(results_ch.delta_vertical),
						int'(want.dv));
				if (results_ch.select_event !== want.select)
					report_mismatch("select_event", int'(results_ch.select_event),
						int'(want.select));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Main sequence
	initial begin
		arst_n                       <= 1'b0;
		psel                         <= 1'b0;
		penable                      <= 1'b0;
		pwrite                       <= 1'b0;
		paddr                        <= '0;
		pwdata                       <= '0;
		samples_ch.valid             <= 1'b0;
		samples_ch.horizontal_sample <= '0;
		samples_ch.vertical_sample   <= '0;
		samples_ch.button_pressed    <= 1'b0;
		samples_ch.now_ms            <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_axis_deadzone();
		test_button_sampling();
		test_register_extremes();
		test_random_traffic();

		drain_moves();
		if (pending_moves.size() != 0)
			report_mismatch("results still outstanding", pending_moves.size(), 0);
		$display("Covered %0d sample sets under %0d register writes: dead zone edges,",
			samples_sent, configs_written);
		$display("  backward and wrapping time, %0d select pulses in %0d checked results.",
			selects_seen, moves_checked);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
